// ----- rtl/mlprq_pkg.sv -----
package mlprq_pkg;

  localparam int LEVELS            = 4;
  localparam int NUM_FIFOS         = 2 * LEVELS;
  localparam int QUEUE_DEPTH_DFLT  = 64;
  localparam int LVL_W             = 2;
  localparam int FIFO_W            = $clog2(NUM_FIFOS);
  localparam int TASK_W            = 8;

  typedef enum logic [1:0] {
    CMD_ENQUEUE  = 2'd0,
    CMD_REQUEUE  = 2'd1,
    CMD_DISPATCH = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_POP  = 1'b1
  } state_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [TASK_W-1:0] task_id;
    logic [LVL_W-1:0]  level;
    logic [LVL_W-1:0]  base_level;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [TASK_W-1:0] out_task_id;
    logic [LVL_W-1:0]  out_level;
    logic              to_expired;
  } out_item_t;

  function automatic logic [LVL_W-1:0] clamp_level(input logic [LVL_W-1:0] v);
    return (int'(v) >= LEVELS) ? LVL_W'(LEVELS - 1) : v;
  endfunction

endpackage

// ----- rtl/mlprq_in_if.sv -----
interface mlprq_in_if;
  logic                 valid;
  logic                 ready;
  mlprq_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/mlprq_out_if.sv -----
interface mlprq_out_if;
  logic                  valid;
  logic                  ready;
  mlprq_pkg::out_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/multilevel_priority_run_queue.sv -----
// Enqueue, requeue, empty dispatch and unused commands: written to the output register.
// Dispatch that pops a task: read into rd_data_r, then into the output register when free.
// Throughput: one push per cycle unless stalled; no new command while a pop is pending.
// Reset (rst_n low, synchronous): all FIFOs empty, bank 0 active, output register empty.
// The queue memory is not cleared; only entries pushed and not yet popped are ever read.
module multilevel_priority_run_queue #(
  parameter int QUEUE_DEPTH = mlprq_pkg::QUEUE_DEPTH_DFLT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mlprq_in_if.sink              in_ch,
  mlprq_out_if.source           out_ch
);

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_D  = mlprq_pkg::NUM_FIFOS * QUEUE_DEPTH;
  localparam int ADDR_W = $clog2(MEM_D);
  localparam int NF     = mlprq_pkg::NUM_FIFOS;
  localparam int FW     = mlprq_pkg::FIFO_W;
  localparam int LW     = mlprq_pkg::LVL_W;
  localparam int TW     = mlprq_pkg::TASK_W;

  logic [TW-1:0]    mem [MEM_D];
  logic [TW-1:0]    rd_data_r;

  logic [PTR_W-1:0] head_r [NF];
  logic [PTR_W-1:0] tail_r [NF];
  logic [CNT_W-1:0] cnt_r  [NF];
  logic             bank_r;
  logic [LW-1:0]    pop_lvl_r;

  mlprq_pkg::state_t    state_r, state_nxt;
  logic                 out_valid_r;
  mlprq_pkg::out_item_t out_item_r;

  logic                 out_free, in_ready_c, accept, pop_done;
  mlprq_pkg::in_item_t  item;
  logic [LW-1:0]        lvl_c, base_c, tgt_lvl, pop_lvl;
  logic                 tgt_bank, bank_nxt, any_act, pop_found;
  logic [FW-1:0]        push_f, pop_f;
  logic                 push_en, pop_en, full_c;
  logic [PTR_W-1:0]     tail_nxt, head_nxt;
  logic [ADDR_W-1:0]    wr_addr, rd_addr;
  mlprq_pkg::out_item_t res_c;
  logic                 load_now;

  assign item     = in_ch.data;
  assign out_free = !out_valid_r || out_ch.ready;
  assign accept   = in_ch.valid && in_ready_c;
  assign in_ch.ready = in_ready_c;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mlprq_pkg::S_IDLE: if (accept && pop_en) state_nxt = mlprq_pkg::S_POP;
      mlprq_pkg::S_POP:  if (out_free) state_nxt = mlprq_pkg::S_IDLE;
      default:           state_nxt = mlprq_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready_c = 1'b0;
    pop_done   = 1'b0;
    unique case (state_r)
      mlprq_pkg::S_IDLE: in_ready_c = out_free;
      mlprq_pkg::S_POP:  pop_done   = out_free;
      default: begin
        in_ready_c = 1'b0;
        pop_done   = 1'b0;
      end
    endcase
  end

  // command decode and queue selection
  always_comb begin
    lvl_c     = mlprq_pkg::clamp_level(item.level);
    base_c    = mlprq_pkg::clamp_level(item.base_level);
    tgt_bank  = bank_r;
    tgt_lvl   = lvl_c;
    any_act   = 1'b0;
    pop_found = 1'b0;
    pop_lvl   = '0;
    res_c     = '0;
    push_en   = 1'b0;
    pop_en    = 1'b0;
    bank_nxt  = bank_r;

    for (int q = 0; q < mlprq_pkg::LEVELS; q++) begin
      if (cnt_r[FW'(bank_r) * FW'(mlprq_pkg::LEVELS) + FW'(q)] != '0) any_act = 1'b1;
    end
    // swap banks when the active one has drained
    bank_nxt = any_act ? bank_r : ~bank_r;
    for (int q = 0; q < mlprq_pkg::LEVELS; q++) begin
      if (cnt_r[FW'(bank_nxt) * FW'(mlprq_pkg::LEVELS) + FW'(q)] != '0) begin
        pop_found = 1'b1;
        pop_lvl   = LW'(q);
      end
    end

    if (item.cmd == mlprq_pkg::CMD_REQUEUE) begin
      if (lvl_c == '0) begin
        tgt_bank = ~bank_r;
        tgt_lvl  = base_c;
      end else begin
        tgt_lvl  = lvl_c - LW'(1);
      end
    end

    push_f = FW'(tgt_bank) * FW'(mlprq_pkg::LEVELS) + FW'(tgt_lvl);
    pop_f  = FW'(bank_nxt) * FW'(mlprq_pkg::LEVELS) + FW'(pop_lvl);
    full_c = (cnt_r[push_f] == CNT_W'(QUEUE_DEPTH));

    unique case (item.cmd)
      mlprq_pkg::CMD_ENQUEUE, mlprq_pkg::CMD_REQUEUE: begin
        push_en          = accept && !full_c;
        res_c.status     = full_c ? mlprq_pkg::ST_FULL : mlprq_pkg::ST_OK;
        res_c.out_level  = tgt_lvl;
        res_c.to_expired = (item.cmd == mlprq_pkg::CMD_REQUEUE) && (lvl_c == '0);
      end
      mlprq_pkg::CMD_DISPATCH: begin
        pop_en       = accept && pop_found;
        res_c.status = mlprq_pkg::ST_EMPTY;
      end
      default: res_c = '0;
    endcase

    tail_nxt = (tail_r[push_f] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r[push_f] + PTR_W'(1);
    head_nxt = (head_r[pop_f] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r[pop_f] + PTR_W'(1);
    wr_addr  = ADDR_W'(push_f) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail_r[push_f]);
    rd_addr  = ADDR_W'(pop_f) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_r[pop_f]);
    load_now = accept && !pop_en;
  end

  // queue memory
  always_ff @(posedge clk) begin
    if (push_en) mem[wr_addr] <= item.task_id;
    if (pop_en)  rd_data_r    <= mem[rd_addr];
  end

  // FIFO pointers, counts and bank
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r <= 1'b0;
      for (int f = 0; f < NF; f++) begin
        head_r[f] <= '0;
        tail_r[f] <= '0;
        cnt_r[f]  <= '0;
      end
    end else begin
      if (accept && item.cmd == mlprq_pkg::CMD_DISPATCH) bank_r <= bank_nxt;
      if (push_en) begin
        tail_r[push_f] <= tail_nxt;
        cnt_r[push_f]  <= cnt_r[push_f] + CNT_W'(1);
      end
      if (pop_en) begin
        head_r[pop_f] <= head_nxt;
        cnt_r[pop_f]  <= cnt_r[pop_f] - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_en) pop_lvl_r <= pop_lvl;
  end

  // state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mlprq_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_now || pop_done) out_valid_r <= 1'b1;
      else if (out_ch.ready)    out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_now) begin
      out_item_r <= res_c;
    end else if (pop_done) begin
      out_item_r.status      <= mlprq_pkg::ST_OK;
      out_item_r.out_task_id <= rd_data_r;
      out_item_r.out_level   <= pop_lvl_r;
      out_item_r.to_expired  <= 1'b0;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;

endmodule
